/* hw/rtl/random_distinct_target_sampler_assert.svh */
// Assertion macros for the distinct target sampler.
// Used by the top level only; needs no package.
`ifndef RANDOM_DISTINCT_TARGET_SAMPLER_ASSERT_SVH
`define RANDOM_DISTINCT_TARGET_SAMPLER_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define RDTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define RDTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/rdts_pkg.sv */
// Shared types and constants of the distinct target sampler.
// No dependencies.
package rdts_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned NodeW    = 6;
  localparam int unsigned CntW     = 7;
  localparam logic [63:0] LcgMul   = 64'd6364136223846793005;
  localparam logic [63:0] LcgInc   = 64'd1442695040888963407;
  localparam logic [63:0] ResetSeed = 64'd12345;

  localparam logic [1:0] RegNodeCount = 2'd0;
  localparam logic [1:0] RegTargets   = 2'd1;
  localparam logic [1:0] RegMode      = 2'd2;
  localparam logic [1:0] RegSeed      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILL, ST_MUL, ST_MOD, ST_READ, ST_OUT
  } state_t;

  // Control from the sequencer to the serial multiplier.
  typedef struct packed {
    logic start;
  } mul_ctl_t;

endpackage

/* hw/rtl/random_distinct_target_sampler.sv */
// Distinct random target sampler: channels, sequencer, node list memory and modulo.
// Depends on rdts_pkg, rdts_lcg_mul and random_distinct_target_sampler_assert.svh.
//
// Usage: a sender index arrives as one beat on in_valid/in_ready. The block
// draws min(targets_per_node, node_count-1) distinct destinations and sends
// each as one beat on out_valid/out_ready, the final one with out_last set.
// A draw of zero gives a single beat with out_empty_res set and target zero.
// node_count counts as at most 64. The node list is filled, then each draw
// runs the bit-serial 64-bit LCG multiply, the restoring modulo of the 31
// high state bits and the list memory access; up to 63 targets are drawn.
// One sender is handled at a time; in_ready is high only when the block is
// idle. The output register holds a beat while the receiver stalls; the
// next draw runs meanwhile, and the sequencer waits for the beat to be
// taken before it sends the next one.
// Reset (synchronous, rst_n low) loads the register reset values and the
// LCG state 12345. Writes on cfg_* take effect at once; writing start_seed
// also reloads the LCG state. Unknown register indexes are ignored.
module random_distinct_target_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  in_sender,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_target,
  output logic        out_last,
  output logic        out_empty_res
);
  import rdts_pkg::*;

  // Configuration registers.
  logic [6:0]  node_count_r;
  logic [5:0]  targets_r;
  logic        mode_r;
  logic [63:0] lcg_r, lcg_nxt;

  state_t state_r, state_nxt;
  logic [5:0] sender_r, sender_nxt;
  logic [5:0] remain_r, remain_nxt;
  logic [CntW-1:0] size_r, size_nxt;
  logic [CntW-1:0] fill_r, fill_nxt;
  logic [CntW-1:0] nsat;
  logic [5:0]  cnt_sat;
  logic [30:0] dvd_r, dvd_nxt;
  logic [CntW-1:0] rem_r, rem_nxt;
  logic [4:0]  mcnt_r, mcnt_nxt;
  logic [CntW:0] trial;
  logic        ov_r, ov_nxt;
  logic [5:0]  ot_r, ot_nxt;
  logic        ol_r, ol_nxt;
  logic        oe_r, oe_nxt;
  logic [5:0]  last_r, last_nxt;
  logic        mem_we;
  logic [5:0]  mem_wa;
  logic [5:0]  mem_wd;
  logic [5:0]  mem_ra;
  logic [5:0]  mem_rd_r;
  logic [5:0]  avail_mem [MaxNodes];
  mul_ctl_t    mul_ctl;
  logic        mul_busy;
  logic [63:0] mul_res;
  logic [CntW-1:0] fill_w;

  rdts_lcg_mul u_mul (
    .clk(clk), .rst_n(rst_n), .ctl_i(mul_ctl), .state_i(lcg_r),
    .busy_o(mul_busy), .result_o(mul_res)
  );

  // Saturated node and target counts.
  always_comb begin
    nsat = (node_count_r > 7'(MaxNodes)) ? 7'(MaxNodes) : node_count_r;
    if (nsat == 7'd0) cnt_sat = 6'd0;
    else if ({1'b0, targets_r} > nsat - 7'd1) cnt_sat = 6'(nsat - 7'd1);
    else cnt_sat = targets_r;
  end

  assign trial  = {rem_r, dvd_r[30]} - {1'b0, size_r};
  assign fill_w = (fill_r >= {1'b0, sender_r}) ? fill_r + 7'd1 : fill_r;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    sender_nxt = sender_r;
    remain_nxt = remain_r;
    size_nxt   = size_r;
    fill_nxt   = fill_r;
    lcg_nxt    = lcg_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    mcnt_nxt   = mcnt_r;
    ov_nxt     = ov_r;
    ot_nxt     = ot_r;
    ol_nxt     = ol_r;
    oe_nxt     = oe_r;
    last_nxt   = last_r;
    mem_we     = 1'b0;
    mem_wa     = 6'(fill_r);
    mem_wd     = 6'(fill_w);
    mem_ra     = 6'(rem_r);
    mul_ctl    = '0;
    in_ready   = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sender_nxt = in_sender;
          if (!mode_r) lcg_nxt = lcg_r + {58'd0, in_sender};
          remain_nxt = cnt_sat;
          if (cnt_sat == 6'd0) begin
            in_ready  = !ov_r || out_ready;
            if (in_ready) begin
              ov_nxt = 1'b1; ot_nxt = 6'd0; ol_nxt = 1'b1; oe_nxt = 1'b1;
            end else begin
              lcg_nxt = lcg_r;
            end
          end else begin
            fill_nxt  = 7'd0;
            size_nxt  = ({1'b0, in_sender} < nsat) ? nsat - 7'd1 : nsat;
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        // Ascending list of all nodes but the sender.
        if (fill_r < size_r) begin
          mem_we   = 1'b1;
          fill_nxt = fill_r + 7'd1;
        end else begin
          mul_ctl.start = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // The last list entry is fetched while the multiply runs.
        mem_ra = 6'(size_r - 7'd1);
        if (!mul_busy) begin
          last_nxt = mem_rd_r;
          lcg_nxt  = mul_res;
          dvd_nxt  = mul_res[63:33];
          rem_nxt  = 7'd0;
          mcnt_nxt = 5'd30;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        // Restoring modulo, one dividend bit a cycle.
        if (!trial[CntW]) rem_nxt = trial[CntW-1:0];
        else rem_nxt = {rem_r[CntW-2:0], dvd_r[30]};
        dvd_nxt = {dvd_r[29:0], 1'b0};
        if (mcnt_r == 5'd0) state_nxt = ST_READ;
        else mcnt_nxt = mcnt_r - 5'd1;
      end
      ST_READ: begin
        mem_ra = 6'(rem_r);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // mem_rd_r holds the chosen entry; the last entry takes its slot.
        mem_ra = 6'(rem_r);
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ot_nxt = mem_rd_r;
          ol_nxt = (remain_r == 6'd1);
          oe_nxt = 1'b0;
          mem_we = 1'b1;
          mem_wa = 6'(rem_r);
          mem_wd = last_r;
          size_nxt   = size_r - 7'd1;
          remain_nxt = remain_r - 6'd1;
          if (remain_r == 6'd1) state_nxt = ST_IDLE;
          else begin
            mul_ctl.start = 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we && cfg_index == RegSeed) lcg_nxt = cfg_data;
  end

  // Node list memory.
  always_ff @(posedge clk) begin
    if (mem_we) avail_mem[mem_wa] <= mem_wd;
    mem_rd_r <= avail_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ov_r         <= 1'b0;
      node_count_r <= 7'd64;
      targets_r    <= 6'd63;
      mode_r       <= 1'b0;
      lcg_r        <= ResetSeed;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      lcg_r   <= lcg_nxt;
      if (cfg_we) begin
        case (cfg_index)
          RegNodeCount: node_count_r <= cfg_data[6:0];
          RegTargets:   targets_r    <= cfg_data[5:0];
          RegMode:      mode_r       <= cfg_data[0];
          default: ;
        endcase
      end
    end
    sender_r <= sender_nxt;
    remain_r <= remain_nxt;
    size_r   <= size_nxt;
    fill_r   <= fill_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    mcnt_r   <= mcnt_nxt;
    ot_r     <= ot_nxt;
    ol_r     <= ol_nxt;
    oe_r     <= oe_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid     = ov_r;
  assign out_target    = ot_r;
  assign out_last      = ol_r;
  assign out_empty_res = oe_r;

  `include "random_distinct_target_sampler_assert.svh"

  `RDTS_ASSERT_IMPL(a_empty_is_last, out_valid && out_empty_res, out_last && out_target == 6'd0)
  `RDTS_ASSERT_IMPL(a_mod_in_range, state_r == ST_READ, rem_r < size_r)
  `RDTS_ASSERT_NEXT(a_mul_runs, state_r == ST_FILL && state_nxt == ST_MUL, mul_busy)
endmodule

/* hw/rtl/rdts_lcg_mul.sv */
// Bit-serial 64-bit LCG step: state * multiplier + increment, mod 2^64.
// Depends on rdts_pkg.
module rdts_lcg_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  rdts_pkg::mul_ctl_t ctl_i,
  input  logic [63:0]       state_i,
  output logic              busy_o,
  output logic [63:0]       result_o
);
  import rdts_pkg::*;

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] mcand_r, mcand_nxt;
  logic [63:0] mplier_r, mplier_nxt;
  logic [6:0]  cnt_r, cnt_nxt;

  // One multiplier bit per cycle, shift-and-add from the low end.
  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    if (ctl_i.start) begin
      acc_nxt    = LcgInc;
      mcand_nxt  = state_i;
      mplier_nxt = LcgMul;
      cnt_nxt    = 7'd64;
    end else if (cnt_r != 7'd0) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = {mcand_r[62:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[63:1]};
      cnt_nxt    = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 7'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign busy_o   = (cnt_r != 7'd0) || ctl_i.start;
  assign result_o = acc_r;
endmodule
